/* rtl/core/vfv_pkg.sv */
package vfv_pkg;

  localparam logic [1:0] CMD_OWN  = 2'd0;
  localparam logic [1:0] CMD_HALO = 2'd1;

  localparam logic [1:0] SIDE_RIGHT = 2'd0;
  localparam logic [1:0] SIDE_LEFT  = 2'd1;
  localparam logic [1:0] SIDE_FRONT = 2'd2;
  localparam logic [1:0] SIDE_BACK  = 2'd3;

  localparam int TOTAL_W = 19;
  localparam int MASK_W  = 6;

  typedef enum logic [1:0] {K_NOP, K_READ, K_OWN, K_HALO} kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] x;
    logic [3:0] z;
    logic [7:0] y;
    logic [1:0] side;
    logic       clr;
  } item_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

  typedef struct packed {
    logic [1:0] count;
  } queue_stat_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOAD, S_CHK, S_TGT, S_NB, S_UPD, S_FRD, S_RES
  } state_t;

  typedef enum logic [1:0] {SRC_VOX, SRC_HALO, SRC_ONE} src_t;

  function automatic logic [2:0] pop6(input logic [MASK_W-1:0] m);
    logic [2:0] n;
    n = 3'd0;
    for (int i = 0; i < MASK_W; i++) begin
      n = n + 3'(m[i]);
    end
    return n;
  endfunction

endpackage

/* rtl/core/vfv_intf.sv */
interface vfv_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [3:0] pos_x;
  logic [3:0] pos_z;
  logic [7:0] pos_y;
  logic [1:0] halo_side;
  logic       is_transparent;

  modport source(output valid, command, pos_x, pos_z, pos_y, halo_side, is_transparent,
                 input ready);
  modport sink(input valid, command, pos_x, pos_z, pos_y, halo_side, is_transparent,
               output ready);
endinterface

interface vfv_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  face_mask;
  logic [18:0] visible_total;

  modport source(output valid, face_mask, visible_total, input ready);
  modport sink(input valid, face_mask, visible_total, output ready);
endinterface

/* rtl/core/voxel_face_visibility_tracker.sv */
// From input transfer to result valid, a read only fetches the face mask, a write that
// leaves transparency unchanged first checks the stored voxel, a halo write refreshes
// the edge voxel beside it, and a voxel write that changes transparency refreshes the
// voxel and its neighbors inside the grid, each through the single read port of the voxel
// store (seven voxel reads per refresh); neighbors outside the grid are skipped.
// Items run one at a time; a stalled result holds the next item back. After reset a
// clearing pass initializes the stores; no item is taken meanwhile.
module voxel_face_visibility_tracker #(
  parameter int EDGE   = 16,
  parameter int LAYERS = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  vfv_in_if.sink     in_chan,
  vfv_out_if.source  out_chan
);

  vfv_pkg::item_t       head;
  logic                 head_valid;
  logic                 pop;
  vfv_pkg::back_stat_t  bstat;
  vfv_pkg::queue_stat_t qstat;

  vfv_front #(.EDGE(EDGE), .LAYERS(LAYERS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .bstat      (bstat),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .qstat      (qstat)
  );

  vfv_back #(.EDGE(EDGE), .LAYERS(LAYERS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .bstat      (bstat),
    .out_chan   (out_chan)
  );

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    bstat.clearing |-> !in_chan.ready)
    else $error("input transfer offered during the clearing pass");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.count != 2'd3)
    else $error("item queue overflow");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("item queue popped while empty");

endmodule

/* rtl/core/vfv_front.sv */
module vfv_front #(
  parameter int EDGE   = 16,
  parameter int LAYERS = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  vfv_in_if.sink                in_chan,
  input  vfv_pkg::back_stat_t   bstat,
  input  logic                  pop,
  output vfv_pkg::item_t        head,
  output logic                  head_valid,
  output vfv_pkg::queue_stat_t  qstat
);

  vfv_pkg::item_t q_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  vfv_pkg::item_t item;
  logic           push;
  logic           xy_ok;
  logic           c_ok;
  logic [3:0]     hc;

  // Range checks and command decoding happen before the queue.
  always_comb begin
    xy_ok = (32'(in_chan.pos_x) < EDGE) && (32'(in_chan.pos_z) < EDGE) &&
            (32'(in_chan.pos_y) < LAYERS);
    hc    = (in_chan.halo_side == vfv_pkg::SIDE_RIGHT ||
             in_chan.halo_side == vfv_pkg::SIDE_LEFT) ? in_chan.pos_x : in_chan.pos_z;
    c_ok  = (32'(hc) < EDGE) && (32'(in_chan.pos_y) < LAYERS);
    item.x    = in_chan.pos_x;
    item.z    = in_chan.pos_z;
    item.y    = in_chan.pos_y;
    item.side = in_chan.halo_side;
    item.clr  = in_chan.is_transparent;
    case (in_chan.command)
      vfv_pkg::CMD_OWN:  item.kind = xy_ok ? vfv_pkg::K_OWN : vfv_pkg::K_NOP;
      vfv_pkg::CMD_HALO: item.kind = c_ok ? vfv_pkg::K_HALO : vfv_pkg::K_NOP;
      default:           item.kind = xy_ok ? vfv_pkg::K_READ : vfv_pkg::K_NOP;
    endcase
  end

  assign in_chan.ready = !bstat.clearing && (cnt_r != 2'd2);
  assign push          = in_chan.valid && in_chan.ready;
  assign head          = q_r[rd_ptr_r];
  assign head_valid    = (cnt_r != 2'd0);
  assign qstat.count   = cnt_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item;
    end
  end

endmodule

/* rtl/core/vfv_back.sv */
module vfv_back #(
  parameter int EDGE   = 16,
  parameter int LAYERS = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vfv_pkg::item_t       head,
  input  logic                 head_valid,
  output logic                 pop,
  output vfv_pkg::back_stat_t  bstat,
  vfv_out_if.source            out_chan
);

  localparam int VOX    = EDGE * EDGE * LAYERS;
  localparam int PLANE  = EDGE * LAYERS;
  localparam int HALO_N = 4 * PLANE;
  localparam int CLR_N  = (VOX > HALO_N) ? VOX : HALO_N;
  localparam int AW     = $clog2(VOX);
  localparam int HAW    = $clog2(HALO_N);
  localparam int CW     = $clog2(CLR_N);
  localparam int XW     = $clog2(EDGE);
  localparam int YW     = $clog2(LAYERS);
  localparam int TW     = vfv_pkg::TOTAL_W;
  localparam int MW     = vfv_pkg::MASK_W;
  localparam logic [XW-1:0] XMAX = XW'(EDGE - 1);
  localparam logic [YW-1:0] YMAX = YW'(LAYERS - 1);

  function automatic logic [AW-1:0] vaddr(input logic [XW-1:0] x, input logic [XW-1:0] z,
                                          input logic [YW-1:0] y);
    return AW'(int'(y) * (EDGE * EDGE) + int'(z) * EDGE + int'(x));
  endfunction

  function automatic logic [HAW-1:0] haddr(input logic [1:0] s, input logic [XW-1:0] c,
                                           input logic [YW-1:0] y);
    return HAW'(int'(s) * PLANE + int'(y) * EDGE + int'(c));
  endfunction

  logic          vox_mem  [VOX];
  logic [MW-1:0] face_mem [VOX];
  logic          halo_mem [HALO_N];

  vfv_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   clr_r, clr_nxt;
  vfv_pkg::item_t  ent_r, ent_nxt;
  logic [XW-1:0]   cx_r, cx_nxt, cz_r, cz_nxt;
  logic [YW-1:0]   cy_r, cy_nxt;
  logic [XW-1:0]   tx_r, tx_nxt, tz_r, tz_nxt;
  logic [YW-1:0]   ty_r, ty_nxt;
  logic [2:0]      tgt_r, tgt_nxt;
  logic [2:0]      step_r, step_nxt;
  vfv_pkg::src_t   src_r, src_nxt;
  logic [6:0]      nb_r, nb_nxt;
  logic            single_r, single_nxt;
  logic [TW-1:0]   total_r, total_nxt;
  logic            out_v_r, out_v_nxt;
  logic [MW-1:0]   out_m_r, out_m_nxt;
  logic [TW-1:0]   out_t_r, out_t_nxt;

  logic            vox_rd_r, halo_rd_r;
  logic [MW-1:0]   face_rd_r;

  logic            vox_we, vox_wd, vox_re;
  logic [AW-1:0]   vox_wa, vox_ra;
  logic            face_we, face_re;
  logic [MW-1:0]   face_wd;
  logic [AW-1:0]   face_wa, face_ra;
  logic            halo_we, halo_wd, halo_re;
  logic [HAW-1:0]  halo_wa, halo_ra;

  logic [XW-1:0]   lx, lz, lc;
  logic            tgt_ok;
  logic [XW-1:0]   nx, nz;
  logic [YW-1:0]   ny;
  logic            nb_bit;
  logic [MW-1:0]   mask_new;
  logic            out_free;
  logic            clr_last;

  // Target and neighbor decoding shared by the state and datapath logic.
  always_comb begin
    lx = XW'(ent_r.x);
    lz = XW'(ent_r.z);
    lc = (ent_r.side == vfv_pkg::SIDE_RIGHT || ent_r.side == vfv_pkg::SIDE_LEFT) ? lx : lz;
    nx = cx_r;
    nz = cz_r;
    ny = cy_r;
    case (tgt_r)
      3'd0: tgt_ok = 1'b1;
      3'd1: begin tgt_ok = (cy_r != YMAX); ny = cy_r + YW'(1); end
      3'd2: begin tgt_ok = (cy_r != '0);   ny = cy_r - YW'(1); end
      3'd3: begin tgt_ok = (cz_r != XMAX); nz = cz_r + XW'(1); end
      3'd4: begin tgt_ok = (cz_r != '0);   nz = cz_r - XW'(1); end
      3'd5: begin tgt_ok = (cx_r != XMAX); nx = cx_r + XW'(1); end
      3'd6: begin tgt_ok = (cx_r != '0);   nx = cx_r - XW'(1); end
      default: tgt_ok = 1'b0;
    endcase
    case (src_r)
      vfv_pkg::SRC_VOX:  nb_bit = vox_rd_r;
      vfv_pkg::SRC_HALO: nb_bit = halo_rd_r;
      default:           nb_bit = 1'b1;
    endcase
    // An exposed-face mask exists only for an opaque voxel.
    mask_new = nb_r[0] ? '0 : {nb_r[2], nb_r[1], nb_r[4], nb_r[3], nb_r[6], nb_r[5]};
    out_free = !out_v_r || out_chan.ready;
    clr_last = (32'(clr_r) == CLR_N - 1);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vfv_pkg::S_CLEAR: if (clr_last) state_nxt = vfv_pkg::S_IDLE;
      vfv_pkg::S_IDLE:  if (head_valid) state_nxt = vfv_pkg::S_LOAD;
      vfv_pkg::S_LOAD: begin
        case (ent_r.kind)
          vfv_pkg::K_NOP:  state_nxt = vfv_pkg::S_RES;
          vfv_pkg::K_READ: state_nxt = vfv_pkg::S_FRD;
          vfv_pkg::K_OWN:  state_nxt = vfv_pkg::S_CHK;
          default:         state_nxt = vfv_pkg::S_TGT;
        endcase
      end
      vfv_pkg::S_CHK:
        state_nxt = (vox_rd_r == ent_r.clr) ? vfv_pkg::S_FRD : vfv_pkg::S_TGT;
      vfv_pkg::S_TGT: begin
        if (tgt_r == 3'd7) state_nxt = vfv_pkg::S_FRD;
        else if (tgt_ok) state_nxt = vfv_pkg::S_NB;
      end
      vfv_pkg::S_NB:  if (step_r == 3'd7) state_nxt = vfv_pkg::S_UPD;
      vfv_pkg::S_UPD: state_nxt = single_r ? vfv_pkg::S_FRD : vfv_pkg::S_TGT;
      vfv_pkg::S_FRD: state_nxt = vfv_pkg::S_RES;
      vfv_pkg::S_RES: if (out_free) state_nxt = vfv_pkg::S_IDLE;
      default:        state_nxt = vfv_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    clr_nxt    = clr_r;
    ent_nxt    = ent_r;
    cx_nxt     = cx_r;
    cz_nxt     = cz_r;
    cy_nxt     = cy_r;
    tx_nxt     = tx_r;
    tz_nxt     = tz_r;
    ty_nxt     = ty_r;
    tgt_nxt    = tgt_r;
    step_nxt   = step_r;
    src_nxt    = src_r;
    nb_nxt     = nb_r;
    single_nxt = single_r;
    total_nxt  = total_r;
    out_m_nxt  = out_m_r;
    out_t_nxt  = out_t_r;
    out_v_nxt  = out_v_r && !out_chan.ready;
    pop        = 1'b0;
    vox_we  = 1'b0; vox_wd  = 1'b1; vox_wa  = vaddr(tx_r, tz_r, ty_r);
    vox_re  = 1'b0; vox_ra  = vaddr(tx_r, tz_r, ty_r);
    face_we = 1'b0; face_wd = mask_new; face_wa = vaddr(tx_r, tz_r, ty_r);
    face_re = 1'b0; face_ra = vaddr(cx_r, cz_r, cy_r);
    halo_we = 1'b0; halo_wd = 1'b1; halo_wa = haddr(ent_r.side, lc, YW'(ent_r.y));
    halo_re = 1'b0; halo_ra = haddr(vfv_pkg::SIDE_RIGHT, tx_r, ty_r);
    case (state_r)
      vfv_pkg::S_CLEAR: begin
        vox_we  = (32'(clr_r) < VOX);
        vox_wa  = clr_r[AW-1:0];
        face_we = (32'(clr_r) < VOX);
        face_wd = '0;
        face_wa = clr_r[AW-1:0];
        halo_we = (32'(clr_r) < HALO_N);
        halo_wa = clr_r[HAW-1:0];
        clr_nxt = clr_r + CW'(1);
      end
      vfv_pkg::S_IDLE: begin
        pop     = head_valid;
        ent_nxt = head;
      end
      vfv_pkg::S_LOAD: begin
        cx_nxt     = lx;
        cz_nxt     = lz;
        cy_nxt     = YW'(ent_r.y);
        tgt_nxt    = 3'd0;
        single_nxt = 1'b0;
        vox_re     = (ent_r.kind == vfv_pkg::K_OWN);
        vox_ra     = vaddr(lx, lz, YW'(ent_r.y));
        if (ent_r.kind == vfv_pkg::K_HALO) begin
          halo_we    = 1'b1;
          halo_wd    = ent_r.clr;
          single_nxt = 1'b1;
          // The halo entry borders exactly one edge voxel of the grid.
          case (ent_r.side)
            vfv_pkg::SIDE_RIGHT: begin cx_nxt = lc;   cz_nxt = XMAX; end
            vfv_pkg::SIDE_LEFT:  begin cx_nxt = lc;   cz_nxt = '0;   end
            vfv_pkg::SIDE_FRONT: begin cx_nxt = XMAX; cz_nxt = lc;   end
            default:             begin cx_nxt = '0;   cz_nxt = lc;   end
          endcase
        end
      end
      vfv_pkg::S_CHK: begin
        if (vox_rd_r != ent_r.clr) begin
          vox_we = 1'b1;
          vox_wd = ent_r.clr;
          vox_wa = vaddr(cx_r, cz_r, cy_r);
        end
      end
      vfv_pkg::S_TGT: begin
        tx_nxt   = nx;
        tz_nxt   = nz;
        ty_nxt   = ny;
        step_nxt = 3'd0;
        if (tgt_r != 3'd7 && !tgt_ok) tgt_nxt = tgt_r + 3'd1;
      end
      vfv_pkg::S_NB: begin
        step_nxt = step_r + 3'd1;
        if (step_r != 3'd0) nb_nxt[step_r - 3'd1] = nb_bit;
        src_nxt = vfv_pkg::SRC_VOX;
        vox_re  = 1'b1;
        case (step_r)
          3'd0: begin
            face_re = 1'b1;
            face_ra = vaddr(tx_r, tz_r, ty_r);
          end
          3'd1: begin
            if (ty_r == YMAX) src_nxt = vfv_pkg::SRC_ONE;
            vox_ra = vaddr(tx_r, tz_r, ty_r + YW'(1));
          end
          3'd2: begin
            if (ty_r == '0) src_nxt = vfv_pkg::SRC_ONE;
            vox_ra = vaddr(tx_r, tz_r, ty_r - YW'(1));
          end
          3'd3: begin
            if (tz_r == XMAX) src_nxt = vfv_pkg::SRC_HALO;
            vox_ra  = vaddr(tx_r, tz_r + XW'(1), ty_r);
            halo_ra = haddr(vfv_pkg::SIDE_RIGHT, tx_r, ty_r);
          end
          3'd4: begin
            if (tz_r == '0) src_nxt = vfv_pkg::SRC_HALO;
            vox_ra  = vaddr(tx_r, tz_r - XW'(1), ty_r);
            halo_ra = haddr(vfv_pkg::SIDE_LEFT, tx_r, ty_r);
          end
          3'd5: begin
            if (tx_r == XMAX) src_nxt = vfv_pkg::SRC_HALO;
            vox_ra  = vaddr(tx_r + XW'(1), tz_r, ty_r);
            halo_ra = haddr(vfv_pkg::SIDE_FRONT, tz_r, ty_r);
          end
          3'd6: begin
            if (tx_r == '0) src_nxt = vfv_pkg::SRC_HALO;
            vox_ra  = vaddr(tx_r - XW'(1), tz_r, ty_r);
            halo_ra = haddr(vfv_pkg::SIDE_BACK, tz_r, ty_r);
          end
          default: vox_re = 1'b0;
        endcase
        halo_re = (step_r >= 3'd3) && (step_r <= 3'd6);
      end
      vfv_pkg::S_UPD: begin
        face_we   = 1'b1;
        total_nxt = total_r - TW'(vfv_pkg::pop6(face_rd_r)) + TW'(vfv_pkg::pop6(mask_new));
        tgt_nxt   = tgt_r + 3'd1;
      end
      vfv_pkg::S_FRD: begin
        face_re = 1'b1;
      end
      vfv_pkg::S_RES: begin
        if (out_free) begin
          out_v_nxt = 1'b1;
          out_m_nxt = (ent_r.kind == vfv_pkg::K_NOP) ? '0 : face_rd_r;
          out_t_nxt = total_r;
        end
      end
      default: ;
    endcase
  end

  assign bstat.clearing         = (state_r == vfv_pkg::S_CLEAR);
  assign out_chan.valid         = out_v_r;
  assign out_chan.face_mask     = out_m_r;
  assign out_chan.visible_total = out_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vfv_pkg::S_CLEAR;
      clr_r   <= '0;
      total_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      total_r <= total_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r    <= ent_nxt;
    cx_r     <= cx_nxt;
    cz_r     <= cz_nxt;
    cy_r     <= cy_nxt;
    tx_r     <= tx_nxt;
    tz_r     <= tz_nxt;
    ty_r     <= ty_nxt;
    tgt_r    <= tgt_nxt;
    step_r   <= step_nxt;
    src_r    <= src_nxt;
    nb_r     <= nb_nxt;
    single_r <= single_nxt;
    out_m_r  <= out_m_nxt;
    out_t_r  <= out_t_nxt;
  end

  always_ff @(posedge clk) begin
    if (vox_we) vox_mem[vox_wa] <= vox_wd;
    if (vox_re) vox_rd_r <= vox_mem[vox_ra];
  end

  always_ff @(posedge clk) begin
    if (face_we) face_mem[face_wa] <= face_wd;
    if (face_re) face_rd_r <= face_mem[face_ra];
  end

  always_ff @(posedge clk) begin
    if (halo_we) halo_mem[halo_wa] <= halo_wd;
    if (halo_re) halo_rd_r <= halo_mem[halo_ra];
  end

endmodule
